>>> rtl/mtwg_pkg.sv
// ----------------------------------------------------------------------------
// mtwg_pkg
// Shared constants, datapath operation codes and helpers for the MT19937
// word generator.
// ----------------------------------------------------------------------------
`default_nettype none

package mtwg_pkg;

   localparam int unsigned STATE_WORDS  = 624;
   localparam int unsigned SHIFT_OFFSET = 397;
   localparam int unsigned IDX_W        = $clog2(STATE_WORDS + 1);

   localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(STATE_WORDS - 1);
   localparam logic [IDX_W-1:0] FULL_IDX   = IDX_W'(STATE_WORDS);
   localparam logic [IDX_W-1:0] FAR_ADD    = IDX_W'(SHIFT_OFFSET);
   localparam logic [IDX_W-1:0] FAR_SUB    = IDX_W'(STATE_WORDS - SHIFT_OFFSET);

   localparam logic [31:0] SEED_MULT  = 32'd1812433253;
   localparam logic [31:0] TWIST_MAG  = 32'h9908_b0df;
   localparam logic [31:0] UPPER_MASK = 32'h8000_0000;
   localparam logic [31:0] LOWER_MASK = 32'h7fff_ffff;
   localparam logic [31:0] TEMPER_B   = 32'h9d2c_5680;
   localparam logic [31:0] TEMPER_C   = 32'hefc6_0000;

   typedef enum logic [3:0] {
      OP_IDLE,
      OP_SEED_INIT,
      OP_SEED_MUL,
      OP_SEED_WR,
      OP_TW_RD,
      OP_TW_FAR,
      OP_TW_WR,
      OP_GEN_RD,
      OP_GEN_OUT
   } dp_op_type;

   typedef struct packed {
      logic cnt_last;    // sweep counter sits on the last state word
      logic index_full;  // state used up, twist needed before next word
   } dp_status_type;

   function automatic logic [31:0] temper(input logic [31:0] x_in);
      logic [31:0] x;
      x = x_in;
      x = x ^ (x >> 11);
      x = x ^ ((x << 7) & TEMPER_B);
      x = x ^ ((x << 15) & TEMPER_C);
      x = x ^ (x >> 18);
      return x;
   endfunction

endpackage

`default_nettype wire

>>> rtl/mt19937_word_generator.sv
// ----------------------------------------------------------------------------
// mt19937_word_generator
// 32-bit Mersenne Twister: seed transactions fill the 624-word state,
// generate transactions return one tempered word each.
//
//   channel   ports                                  direction
//   request   start, busy, req_mode, req_seed_value  in (busy out)
//   response  rsp_strobe, rsp_random_word            out
//
// Seed: word 0 is written at the accepting edge, then busy while each
//   of the other 623 words gets a multiply step, then an add-and-write step.
// Generate: busy through a read step and a temper step; when the state is used
//   up a twist runs first: read, far read, write per word (single-write memory).
// The word appears on rsp_random_word with rsp_strobe in the first cycle with
//   busy low; the receiver cannot stall it.
// Reset clears the sequencer and sets the word index to 624; the state memory
//   holds nothing useful until the first seed.
// ----------------------------------------------------------------------------
`default_nettype none

module mt19937_word_generator import mtwg_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output      logic        busy,
   input  wire logic        req_mode,
   input  wire logic [31:0] req_seed_value,
   output      logic        rsp_strobe,
   output      logic [31:0] rsp_random_word
);

   dp_op_type     op;
   dp_status_type status;

   mtwg_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_mode (req_mode),
      .status   (status),
      .op       (op),
      .busy     (busy)
   );

   mtwg_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .op              (op),
      .req_seed_value  (req_seed_value),
      .status          (status),
      .rsp_strobe      (rsp_strobe),
      .rsp_random_word (rsp_random_word)
   );

   // a word only comes out of a generate transaction that was in progress
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("response without a transaction in progress");

   // a seed transaction never produces a response
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !req_mode) |=> !rsp_strobe)
      else $error("response after seed transaction");

   // an accepted transaction always occupies the block
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after accepted transaction");

   // twisting only starts once the whole state has been consumed
   assert property (@(posedge clock) disable iff (reset)
      (op == OP_TW_RD && $past(op) == OP_IDLE) |-> status.index_full)
      else $error("twist started with words left");

endmodule

`default_nettype wire

>>> rtl/mtwg_ctrl.sv
// ----------------------------------------------------------------------------
// mtwg_ctrl
// Sequencer for seeding, twisting and word readout; drives one datapath
// operation per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mtwg_ctrl import mtwg_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic          req_mode,
   input  wire dp_status_type status,
   output      dp_op_type     op,
   output      logic          busy
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEED_MUL,
      ST_SEED_WR,
      ST_TW_RD,
      ST_TW_FAR,
      ST_TW_WR,
      ST_GEN_RD,
      ST_GEN_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff, busy_in;
   logic      accept;

   assign accept = start && !busy_ff;
   assign busy   = busy_ff;

   always_comb begin
      state_in = state_ff;
      busy_in  = busy_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               busy_in = 1'b1;
               if (!req_mode) begin
                  state_in = ST_SEED_MUL;
               end else if (status.index_full) begin
                  state_in = ST_TW_RD;
               end else begin
                  state_in = ST_GEN_RD;
               end
            end
         end
         ST_SEED_MUL: state_in = ST_SEED_WR;
         ST_SEED_WR: begin
            if (status.cnt_last) begin
               state_in = ST_IDLE;
               busy_in  = 1'b0;
            end else begin
               state_in = ST_SEED_MUL;
            end
         end
         ST_TW_RD:  state_in = ST_TW_FAR;
         ST_TW_FAR: state_in = ST_TW_WR;
         ST_TW_WR:  state_in = status.cnt_last ? ST_GEN_RD : ST_TW_RD;
         ST_GEN_RD: state_in = ST_GEN_OUT;
         ST_GEN_OUT: begin
            state_in = ST_IDLE;
            busy_in  = 1'b0;
         end
         default: begin
            state_in = ST_IDLE;
            busy_in  = 1'b0;
         end
      endcase
   end

   always_comb begin
      unique case (state_ff)
         ST_IDLE:     op = (accept && !req_mode) ? OP_SEED_INIT : OP_IDLE;
         ST_SEED_MUL: op = OP_SEED_MUL;
         ST_SEED_WR:  op = OP_SEED_WR;
         ST_TW_RD:    op = OP_TW_RD;
         ST_TW_FAR:   op = OP_TW_FAR;
         ST_TW_WR:    op = OP_TW_WR;
         ST_GEN_RD:   op = OP_GEN_RD;
         ST_GEN_OUT:  op = OP_GEN_OUT;
         default:     op = OP_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= busy_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/mtwg_dp.sv
// ----------------------------------------------------------------------------
// mtwg_dp
// State memory, seed multiplier, twist recurrence, word index and tempering
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mtwg_dp import mtwg_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire dp_op_type     op,
   input  wire logic [31:0]   req_seed_value,
   output      dp_status_type status,
   output      logic          rsp_strobe,
   output      logic [31:0]   rsp_random_word
);

   logic [31:0] mem [STATE_WORDS];

   logic [IDX_W-1:0] cnt_ff, cnt_in;
   logic [IDX_W-1:0] index_ff, index_in;
   logic [31:0]      x_ff, x_in;
   logic [31:0]      prod_ff;
   logic [31:0]      y_ff;
   logic [31:0]      rd_a_ff, rd_b_ff;
   logic [31:0]      word_ff;
   logic             strobe_ff;

   logic [IDX_W-1:0] addr_a, addr_b, wr_addr;
   logic [IDX_W-1:0] nxt_idx, far_idx, cnt_inc;
   logic             wr_en;
   logic [31:0]      wr_data;
   logic [31:0]      seed_next, twist_val, y_val;
   logic             cnt_last;

   assign cnt_last = (cnt_ff == LAST_IDX);
   assign cnt_inc  = cnt_last ? '0 : IDX_W'(cnt_ff + 1'b1);
   assign nxt_idx  = cnt_inc;
   // words from STATE_WORDS - SHIFT_OFFSET on reach back into already twisted words
   assign far_idx  = (cnt_ff < FAR_SUB) ? IDX_W'(cnt_ff + FAR_ADD)
                                        : IDX_W'(cnt_ff - FAR_SUB);

   assign seed_next = prod_ff + {{(32-IDX_W){1'b0}}, cnt_ff};
   assign y_val     = (rd_a_ff & UPPER_MASK) | (rd_b_ff & LOWER_MASK);
   assign twist_val = rd_a_ff ^ (y_ff >> 1) ^ (y_ff[0] ? TWIST_MAG : 32'd0);

   assign status = '{cnt_last: cnt_last, index_full: (index_ff == FULL_IDX)};

   always_comb begin
      cnt_in   = cnt_ff;
      index_in = index_ff;
      x_in     = x_ff;
      addr_a   = cnt_ff;
      addr_b   = nxt_idx;
      wr_en    = 1'b0;
      wr_addr  = cnt_ff;
      wr_data  = twist_val;
      unique case (op)
         OP_SEED_INIT: begin
            wr_en    = 1'b1;
            wr_addr  = '0;
            wr_data  = req_seed_value;
            x_in     = req_seed_value;
            cnt_in   = IDX_W'(1);
            index_in = FULL_IDX;
         end
         OP_SEED_WR: begin
            wr_en   = 1'b1;
            wr_data = seed_next;
            x_in    = seed_next;
            cnt_in  = cnt_inc;
         end
         OP_TW_FAR: addr_a = far_idx;
         OP_TW_WR: begin
            wr_en  = 1'b1;
            cnt_in = cnt_inc;
            if (cnt_last) begin
               index_in = '0;
            end
         end
         OP_GEN_RD:  addr_a = index_ff;
         OP_GEN_OUT: index_in = IDX_W'(index_ff + 1'b1);
         OP_IDLE, OP_SEED_MUL, OP_TW_RD: ;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem[addr_a];
      rd_b_ff <= mem[addr_b];
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      prod_ff <= SEED_MULT * (x_ff ^ (x_ff >> 30));
      if (op == OP_TW_FAR) begin
         y_ff <= y_val;
      end
      if (op == OP_GEN_OUT) begin
         word_ff <= temper(rd_a_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         index_ff  <= FULL_IDX;
         strobe_ff <= 1'b0;
      end else begin
         cnt_ff    <= cnt_in;
         index_ff  <= index_in;
         strobe_ff <= (op == OP_GEN_OUT);
      end
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_random_word = word_ff;

endmodule

`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives seed and generate transactions into the MT19937 word generator: a
// directed table first, then random seed runs, one of them long enough to
// cross several twists. Every word is checked against an in-bench generator or a known answer from the table.
// ----------------------------------------------------------------------------

module testbench;
   import mtwg_pkg::*;

   localparam logic MODE_SEED    = 1'b0;
   localparam logic MODE_GEN     = 1'b1;
   localparam int   ITEM_TARGET  = 1350;
   localparam int   LONG_RUN     = 1260;   // three twists after one seed
   localparam int   STALL_LIMIT  = 20000;
   localparam int   DRAIN_CYCLES = 2000;   // covers a trailing seed
   localparam int   MAX_REPORTS  = 50;

   typedef struct packed {
      logic        mode;
      logic [31:0] seed;
      logic        typed;   // word below is the known answer
      logic [31:0] word;
   } dir_row_type;

   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        start          = 1'b0;
   logic        req_mode       = 1'b0;
   logic [31:0] req_seed_value = '0;
   logic        busy;
   logic        rsp_strobe;
   logic [31:0] rsp_random_word;

   mt19937_word_generator dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_mode       (req_mode),
      .req_seed_value (req_seed_value),
      .rsp_strobe     (rsp_strobe),
      .rsp_random_word(rsp_random_word)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // generator model
   logic [31:0] mt_words [STATE_WORDS];
   int unsigned mt_pos = STATE_WORDS;

   logic [31:0] pending_words [$];
   logic [31:0] want_word;
   int          err_count  = 0;
   int          items_sent = 0;
   int          idle_pct   = 0;
   int          stall_cnt  = 0;

   function automatic void mt_seed(input logic [31:0] s);
      mt_words[0] = s;
      for (int i = 1; i < STATE_WORDS; i++)
         mt_words[i] = SEED_MULT * (mt_words[i-1] ^ (mt_words[i-1] >> 30)) + 32'(i);
      mt_pos = STATE_WORDS;
   endfunction

   function automatic void mt_twist();
      logic [31:0] y;
      logic [31:0] v;
      for (int k = 0; k < STATE_WORDS; k++) begin
         y = (mt_words[k] & UPPER_MASK) | (mt_words[(k + 1) % STATE_WORDS] & LOWER_MASK);
         v = mt_words[(k + SHIFT_OFFSET) % STATE_WORDS] ^ (y >> 1);
         if (y[0]) v = v ^ TWIST_MAG;
         mt_words[k] = v;
      end
      mt_pos = 0;
   endfunction

   function automatic logic [31:0] mt_temper(input logic [31:0] w);
      logic [31:0] t;
      t = w ^ {11'b0, w[31:11]};
      t = t ^ ({t[24:0], 7'b0} & TEMPER_B);
      t = t ^ ({t[16:0], 15'b0} & TEMPER_C);
      return t ^ {18'b0, t[31:18]};
   endfunction

   function automatic logic [31:0] mt_next_word();
      logic [31:0] w;
      if (mt_pos >= STATE_WORDS) mt_twist();
      w = mt_temper(mt_words[mt_pos]);
      mt_pos++;
      return w;
   endfunction

   task automatic report_mismatch(input string what);
      err_count++;
      if (err_count <= MAX_REPORTS) $display("%0t: mismatch: %s", $time, what);
   endtask

   // one transaction; expectation queued once busy has dropped
   task automatic send_item(input logic m, input logic [31:0] s,
                            input logic typed, input logic [31:0] tw);
      logic [31:0] w;
      case (items_sent * 4 / ITEM_TARGET)
         1:       idle_pct = 50;
         3:       idle_pct = 36;
         default: idle_pct = 0;
      endcase
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start          <= 1'b1;
      req_mode       <= m;
      req_seed_value <= s;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (m == MODE_SEED) begin
         mt_seed(s);
      end else begin
         w = mt_next_word();
         pending_words.push_back(typed ? tw : w);
      end
      items_sent++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (pending_words.size() == 0) begin
            report_mismatch($sformatf("word %h with none pending", rsp_random_word));
         end else begin
            want_word = pending_words.pop_front();
            if (rsp_random_word !== want_word)
               report_mismatch($sformatf("random_word %h, want %h",
                                         rsp_random_word, want_word));
         end
      end
   end

   // watchdog: cycles with no transaction on either side
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         stall_cnt <= 0;
      end else if (stall_cnt >= STALL_LIMIT) begin
         $display("testbench NOT OK");
         $finish;
      end else begin
         stall_cnt <= stall_cnt + 1;
      end
   end

   initial begin
      dir_row_type dir_tab [18];
      logic [31:0] s;
      int          run;
      bit          long_done;
      dir_tab = '{
         '{MODE_SEED, 32'd5489,       1'b0, 32'd0},
         '{MODE_GEN,  32'h0000_0000, 1'b1, 32'd3499211612},
         '{MODE_GEN,  32'hffff_ffff, 1'b0, 32'd0},   // seed field ignored
         '{MODE_GEN,  32'h0000_0000, 1'b0, 32'd0},
         '{MODE_SEED, 32'h0000_0000, 1'b0, 32'd0},
         '{MODE_GEN,  32'h1234_5678, 1'b1, 32'd2357136044},
         '{MODE_GEN,  32'h0000_0000, 1'b0, 32'd0},
         '{MODE_SEED, 32'hffff_ffff, 1'b0, 32'd0},
         '{MODE_GEN,  32'hffff_ffff, 1'b0, 32'd0},
         '{MODE_GEN,  32'h0000_0000, 1'b0, 32'd0},
         '{MODE_SEED, 32'h8000_0000, 1'b0, 32'd0},
         '{MODE_GEN,  32'h8000_0000, 1'b0, 32'd0},
         '{MODE_SEED, 32'h0000_0001, 1'b0, 32'd0},
         '{MODE_GEN,  32'h0000_0001, 1'b0, 32'd0},
         '{MODE_SEED, 32'haaaa_aaaa, 1'b0, 32'd0},
         '{MODE_SEED, 32'h5555_5555, 1'b0, 32'd0},   // back-to-back reseed
         '{MODE_GEN,  32'haaaa_aaaa, 1'b0, 32'd0},
         '{MODE_GEN,  32'h5555_5555, 1'b0, 32'd0}
      };
      long_done = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_tab[i])
         send_item(dir_tab[i].mode, dir_tab[i].seed, dir_tab[i].typed, dir_tab[i].word);

      // seed runs: mostly short, some crossing a twist, reseeding mid-state
      while (items_sent < ITEM_TARGET) begin
         case ($urandom_range(0, 7))
            0:       s = '0;
            1:       s = '1;
            default: s = $urandom();
         endcase
         send_item(MODE_SEED, s, 1'b0, '0);
         if (!long_done)
            run = LONG_RUN;
         else if ($urandom_range(0, 3) == 0)
            run = $urandom_range(620, 700);
         else
            run = $urandom_range(0, 30);
         long_done = 1'b1;
         for (int j = 0; j < run && items_sent < ITEM_TARGET; j++)
            send_item(MODE_GEN, $urandom(), 1'b0, '0);
      end
      start <= 1'b0;

      while (pending_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (err_count == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule
